### sv/pfc_pkg.sv
// Shared types, format codes and channel scaling functions for the pixel format converter.
`timescale 1ns / 1ps

package pfc_pkg;

  typedef enum logic [2:0] {
    FmtR8G8B8   = 3'd0,
    FmtR5G6B5   = 3'd1,
    FmtX1R5G5B5 = 3'd2,
    FmtA1R5G5B5 = 3'd3,
    FmtA4R4G4B4 = 3'd4,
    FmtX8R8G8B8 = 3'd5,
    FmtA8R8G8B8 = 3'd6
  } fmt_e;

  typedef enum logic [1:0] {
    CfgSourceFormat = 2'd0,
    CfgDestFormat   = 2'd1,
    CfgColorKey     = 2'd2,
    CfgAllowRawCopy = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  localparam logic [31:0] ColorKeyOff   = 32'd0;
  localparam logic [7:0]  AlphaOpaque   = 8'd255;
  localparam logic [7:0]  AlphaClear    = 8'd0;
  localparam logic [23:0] KeyRgbMask    = 24'hFF_FFFF;

  // Reciprocals for exact floor division of the narrow products below.
  localparam logic [13:0] Recip31  = 14'd8457;   // ceil(2^18 / 31)
  localparam logic [14:0] Recip63  = 15'd16645;  // ceil(2^20 / 63)
  localparam logic [13:0] Recip255a = 14'd8225;  // ceil(2^21 / 255)
  localparam logic [14:0] Recip255b = 15'd16449; // ceil(2^22 / 255)

  // v * 255 / 31, floor.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] n;
    logic [26:0] p;
    n = {v, 8'd0} - {8'd0, v};
    p = 27'(n) * 27'(Recip31);
    return p[25:18];
  endfunction

  // v * 255 / 63, floor.
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] n;
    logic [28:0] p;
    n = {v, 8'd0} - {8'd0, v};
    p = 29'(n) * 29'(Recip63);
    return p[27:20];
  endfunction

  // c * 31 / 255, floor.
  function automatic logic [4:0] pack5(input logic [7:0] c);
    logic [12:0] n;
    logic [26:0] p;
    n = {c, 5'd0} - {5'd0, c};
    p = 27'(n) * 27'(Recip255a);
    return p[25:21];
  endfunction

  // c * 63 / 255, floor.
  function automatic logic [5:0] pack6(input logic [7:0] c);
    logic [13:0] n;
    logic [28:0] p;
    n = {c, 6'd0} - {6'd0, c};
    p = 29'(n) * 29'(Recip255b);
    return p[27:22];
  endfunction

  function automatic logic [2:0] byte_count(input logic [2:0] fmt);
    logic [2:0] nb;
    unique case (fmt_e'(fmt))
      FmtR8G8B8:   nb = 3'd3;
      FmtR5G6B5,
      FmtX1R5G5B5,
      FmtA1R5G5B5,
      FmtA4R4G4B4: nb = 3'd2;
      default:     nb = 3'd4;
    endcase
    return nb;
  endfunction

endpackage

### sv/pfc_expand.sv
// Unpacks a source pixel of any supported format into 8-bit R, G, B and A.
`timescale 1ns / 1ps

module pfc_expand import pfc_pkg::*; (
  input  logic [2:0]  fmt_i,
  input  logic [31:0] pixel_i,
  output rgba_t       rgba_o
);

  logic [15:0] w;

  assign w = pixel_i[15:0];

  always_comb begin
    unique case (fmt_e'(fmt_i))
      FmtR8G8B8: begin
        rgba_o.r = pixel_i[23:16];
        rgba_o.g = pixel_i[15:8];
        rgba_o.b = pixel_i[7:0];
        rgba_o.a = AlphaOpaque;
      end
      FmtR5G6B5: begin
        rgba_o.r = expand5(w[15:11]);
        rgba_o.g = expand6(w[10:5]);
        rgba_o.b = expand5(w[4:0]);
        rgba_o.a = AlphaOpaque;
      end
      FmtX1R5G5B5: begin
        rgba_o.r = expand5(w[14:10]);
        rgba_o.g = expand5(w[9:5]);
        rgba_o.b = expand5(w[4:0]);
        rgba_o.a = AlphaOpaque;
      end
      FmtA1R5G5B5: begin
        rgba_o.r = expand5(w[14:10]);
        rgba_o.g = expand5(w[9:5]);
        rgba_o.b = expand5(w[4:0]);
        rgba_o.a = w[15] ? AlphaOpaque : AlphaClear;
      end
      FmtA4R4G4B4: begin
        rgba_o.r = {w[11:8], w[11:8]};
        rgba_o.g = {w[7:4], w[7:4]};
        rgba_o.b = {w[3:0], w[3:0]};
        rgba_o.a = {w[15:12], w[15:12]};
      end
      FmtX8R8G8B8: begin
        rgba_o.r = pixel_i[23:16];
        rgba_o.g = pixel_i[15:8];
        rgba_o.b = pixel_i[7:0];
        rgba_o.a = AlphaOpaque;
      end
      default: begin
        // A8R8G8B8, and the spare code seven which behaves the same.
        rgba_o.r = pixel_i[23:16];
        rgba_o.g = pixel_i[15:8];
        rgba_o.b = pixel_i[7:0];
        rgba_o.a = pixel_i[31:24];
      end
    endcase
  end

endmodule

### sv/pfc_pack.sv
// Packs 8-bit R, G, B and A into a destination pixel of any supported format.
`timescale 1ns / 1ps

module pfc_pack import pfc_pkg::*; (
  input  logic [2:0]  fmt_i,
  input  rgba_t       rgba_i,
  output logic [31:0] pixel_o
);

  always_comb begin
    unique case (fmt_e'(fmt_i))
      FmtR8G8B8: begin
        pixel_o = {8'd0, rgba_i.r, rgba_i.g, rgba_i.b};
      end
      FmtR5G6B5: begin
        pixel_o = {16'd0, pack5(rgba_i.r), pack6(rgba_i.g), pack5(rgba_i.b)};
      end
      FmtX1R5G5B5: begin
        pixel_o = {16'd0, 1'b1, pack5(rgba_i.r), pack5(rgba_i.g), pack5(rgba_i.b)};
      end
      FmtA1R5G5B5: begin
        pixel_o = {16'd0, rgba_i.a[7], pack5(rgba_i.r), pack5(rgba_i.g),
                   pack5(rgba_i.b)};
      end
      FmtA4R4G4B4: begin
        pixel_o = {16'd0, rgba_i.a[7:4], rgba_i.r[7:4], rgba_i.g[7:4], rgba_i.b[7:4]};
      end
      FmtX8R8G8B8: begin
        pixel_o = {AlphaOpaque, rgba_i.r, rgba_i.g, rgba_i.b};
      end
      default: begin
        pixel_o = {rgba_i.a, rgba_i.r, rgba_i.g, rgba_i.b};
      end
    endcase
  end

endmodule

### sv/pixel_format_converter.sv
// Top level of the pixel format converter: configuration, input and result registers.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   source_pixel_i
//   result    out        out_valid_o / out_stall_i dest_pixel_o, dest_bytes_o
//   config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One pixel per clock unless the output stalls; accepted pixels move into the result register.
// The input register and the result register form a two-stage pipeline, so a new pixel is taken
// while a finished one waits; the input stalls only when both stages are full and the output
// is stalled. Reset empties both stages and loads the register defaults.
`timescale 1ns / 1ps

module pixel_format_converter import pfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] source_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] dest_pixel_o,
  output logic [2:0]  dest_bytes_o
);

  logic [2:0]  source_format_q;
  logic [2:0]  dest_format_q;
  logic [31:0] color_key_q;
  logic        allow_raw_copy_q;

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_pixel_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] dest_pixel_q, dest_pixel_d;
  logic [2:0]  dest_bytes_q, dest_bytes_d;

  logic        s1_en, s2_en;
  rgba_t       rgba_src, rgba_key;
  logic [31:0] packed_pixel, res_pixel;
  logic        key_hit, raw_copy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_format_q  <= FmtA8R8G8B8;
      dest_format_q    <= FmtA8R8G8B8;
      color_key_q      <= ColorKeyOff;
      allow_raw_copy_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSourceFormat: source_format_q  <= cfg_wdata_i[2:0];
        CfgDestFormat:   dest_format_q    <= cfg_wdata_i[2:0];
        CfgColorKey:     color_key_q      <= cfg_wdata_i;
        CfgAllowRawCopy: allow_raw_copy_q <= cfg_wdata_i[0];
      endcase
    end
  end

  // The result register advances when empty or taken; the input register when it can pass on.
  assign s2_en      = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  assign s1_valid_d  = s1_en ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_en ? s1_valid_q : out_valid_q;

  pfc_expand u_expand (
    .fmt_i   (source_format_q),
    .pixel_i (s1_pixel_q),
    .rgba_o  (rgba_src)
  );

  assign key_hit = (color_key_q != ColorKeyOff) &&
                   ((color_key_q[23:0] & KeyRgbMask) == {rgba_src.r, rgba_src.g, rgba_src.b});

  always_comb begin
    rgba_key = rgba_src;
    if (key_hit) begin
      rgba_key.a = AlphaClear;
    end
  end

  pfc_pack u_pack (
    .fmt_i   (dest_format_q),
    .rgba_i  (rgba_key),
    .pixel_o (packed_pixel)
  );

  assign raw_copy = (source_format_q == dest_format_q) && (color_key_q == ColorKeyOff) &&
                    allow_raw_copy_q;
  assign res_pixel = raw_copy ? s1_pixel_q : packed_pixel;

  assign dest_bytes_d = byte_count(dest_format_q);

  always_comb begin
    unique case (dest_bytes_d)
      3'd2:    dest_pixel_d = {16'd0, res_pixel[15:0]};
      3'd3:    dest_pixel_d = {8'd0, res_pixel[23:0]};
      default: dest_pixel_d = res_pixel;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_pixel_q <= source_pixel_i;
    end
    if (s2_en && s1_valid_q) begin
      dest_pixel_q <= dest_pixel_d;
      dest_bytes_q <= dest_bytes_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_pixel_o = dest_pixel_q;
  assign dest_bytes_o = dest_bytes_q;

endmodule

### sv/pfc_checker.sv
// Port-level checks on the pixel format converter, bound to the top level.
`timescale 1ns / 1ps

module pfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] dest_pixel_o,
  input logic [2:0]  dest_bytes_o
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dest_pixel_o) &&
                                   $stable(dest_bytes_o))
    else $error("result changed while stalled");

  // The input only stalls when both pipeline stages are occupied and the output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // A result appearing in an empty output stage comes from an earlier input transaction.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a matching input transaction");

  // Byte count is legal and bytes beyond it are zero.
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dest_bytes_o == 3'd4) ||
                    (dest_bytes_o == 3'd3 && dest_pixel_o[31:24] == 8'd0) ||
                    (dest_bytes_o == 3'd2 && dest_pixel_o[31:16] == 16'd0))
    else $error("bad byte count or unused bytes not zero");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for the pixel format converter: directed and random pixel streams.
`timescale 1ns / 1ps

module tb_top import pfc_pkg::*;;

  // Format code seven is outside the enum but decodes as A8R8G8B8.
  localparam logic [2:0] FmtSpare = 3'd7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [31:0] pixel;
    logic [2:0]  nbytes;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_idx = CfgSourceFormat;
  logic [31:0] cfg_wdata = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] source_pixel = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] dest_pixel;
  logic [2:0]  dest_bytes;

  // Register shadow used when predicting each pixel.
  logic [2:0]  src_fmt = FmtA8R8G8B8;
  logic [2:0]  dst_fmt = FmtA8R8G8B8;
  logic [31:0] key_rgb = ColorKeyOff;
  logic        raw_copy = 1'b1;

  pixel_result_t expected_pixels[$];
  int unsigned   mismatch_count = 0;
  int unsigned   stray_count = 0;
  int unsigned   cycle_count = 0;
  bit            idle_on = 1'b1;
  bit            result_taken = 1'b0;
  int unsigned   stall_left = 0;

  pixel_format_converter i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .source_pixel_i(source_pixel),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .dest_pixel_o  (dest_pixel),
    .dest_bytes_o  (dest_bytes)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic rgba_t expand_to_rgba(logic [31:0] px, logic [2:0] fmt);
    rgba_t c;
    c.a = AlphaOpaque;
    case (fmt)
      FmtR8G8B8: begin
        c.r = px[23:16]; c.g = px[15:8]; c.b = px[7:0];
      end
      FmtR5G6B5: begin
        c.r = 8'(int'(px[15:11]) * 255 / 31);
        c.g = 8'(int'(px[10:5]) * 255 / 63);
        c.b = 8'(int'(px[4:0]) * 255 / 31);
      end
      FmtX1R5G5B5, FmtA1R5G5B5: begin
        c.r = 8'(int'(px[14:10]) * 255 / 31);
        c.g = 8'(int'(px[9:5]) * 255 / 31);
        c.b = 8'(int'(px[4:0]) * 255 / 31);
        if (fmt == FmtA1R5G5B5 && !px[15]) c.a = AlphaClear;
      end
      FmtA4R4G4B4: begin
        c.r = 8'(int'(px[11:8]) * 17);
        c.g = 8'(int'(px[7:4]) * 17);
        c.b = 8'(int'(px[3:0]) * 17);
        c.a = 8'(int'(px[15:12]) * 17);
      end
      default: begin
        c.r = px[23:16]; c.g = px[15:8]; c.b = px[7:0];
        if (fmt != FmtX8R8G8B8) c.a = px[31:24];
      end
    endcase
    return c;
  endfunction

  // Works out the converted pixel and its byte count under the current register shadow.
  function automatic pixel_result_t convert_pixel(logic [31:0] px);
    pixel_result_t res;
    rgba_t c;
    logic [31:0] packed_px;
    logic [31:0] keep_mask;
    case (dst_fmt)
      FmtR8G8B8: begin res.nbytes = 3'd3; keep_mask = 32'h00FF_FFFF; end
      FmtR5G6B5, FmtX1R5G5B5, FmtA1R5G5B5, FmtA4R4G4B4: begin
        res.nbytes = 3'd2; keep_mask = 32'h0000_FFFF;
      end
      default: begin res.nbytes = 3'd4; keep_mask = 32'hFFFF_FFFF; end
    endcase
    if (src_fmt == dst_fmt && key_rgb == ColorKeyOff && raw_copy) begin
      packed_px = px;
    end else begin
      c = expand_to_rgba(px, src_fmt);
      if (key_rgb != ColorKeyOff && key_rgb[23:0] == {c.r, c.g, c.b}) c.a = AlphaClear;
      packed_px = 32'd0;
      case (dst_fmt)
        FmtR8G8B8: packed_px[23:0] = {c.r, c.g, c.b};
        FmtR5G6B5: begin
          packed_px[15:11] = 5'(int'(c.r) * 31 / 255);
          packed_px[10:5]  = 6'(int'(c.g) * 63 / 255);
          packed_px[4:0]   = 5'(int'(c.b) * 31 / 255);
        end
        FmtX1R5G5B5, FmtA1R5G5B5: begin
          packed_px[15]    = (dst_fmt == FmtX1R5G5B5) || (int'(c.a) >= 128);
          packed_px[14:10] = 5'(int'(c.r) * 31 / 255);
          packed_px[9:5]   = 5'(int'(c.g) * 31 / 255);
          packed_px[4:0]   = 5'(int'(c.b) * 31 / 255);
        end
        FmtA4R4G4B4: packed_px[15:0] = {c.a[7:4], c.r[7:4], c.g[7:4], c.b[7:4]};
        FmtX8R8G8B8: packed_px = {AlphaOpaque, c.r, c.g, c.b};
        default:     packed_px = {c.a, c.r, c.g, c.b};
      endcase
    end
    res.pixel = packed_px & keep_mask;
    return res;
  endfunction

  // Results are sampled on the falling edge before the edge that takes them.
  always @(negedge clk) begin
    pixel_result_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (expected_pixels.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= ReportLimit)
          $display("unexpected result: dest_pixel %h dest_bytes %0d", dest_pixel, dest_bytes);
      end else begin
        exp_px = expected_pixels.pop_front();
        if (dest_pixel !== exp_px.pixel || dest_bytes !== exp_px.nbytes) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= ReportLimit)
            $display("mismatch: dest_pixel %h (expected %h), dest_bytes %0d (expected %0d)",
                     dest_pixel, exp_px.pixel, dest_bytes, exp_px.nbytes);
        end
      end
    end
  end

  // While idling is on, the receiver holds off for a random number of cycles after each
  // transaction and now and then stalls at random, whether or not a result is offered.
  always @(posedge clk) begin
    if (result_taken) begin
      stall_left = idle_on ? $urandom_range(0, 7) : 0;
      result_taken = 1'b0;
    end else if (idle_on && stall_left == 0 && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(logic [31:0] px);
    int unsigned gap;
    bit accepted;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    source_pixel <= px;
    do begin
      @(negedge clk);
      accepted = !in_stall;
      if (accepted) expected_pixels.push_back(convert_pixel(px));
      @(posedge clk);
    end while (!accepted);
  endtask

  // Stops sending and waits for every outstanding pixel to come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      CfgSourceFormat: src_fmt = value[2:0];
      CfgDestFormat:   dst_fmt = value[2:0];
      CfgColorKey:     key_rgb = value;
      default:         raw_copy = value[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] src, logic [31:0] dst, logic [31:0] key,
                            logic [31:0] raw);
    drain();
    write_reg(CfgSourceFormat, src);
    write_reg(CfgDestFormat, dst);
    write_reg(CfgColorKey, key);
    write_reg(CfgAllowRawCopy, raw);
  endtask

  task automatic test_reset_defaults();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
  endtask

  task automatic test_raw_copy();
    set_config(32'(FmtR5G6B5), 32'(FmtR5G6B5), ColorKeyOff, 32'd1);
    send_pixel(32'hDEAD_BEEF);
    set_config(32'(FmtR8G8B8), {29'h1FFF_FFFF, FmtR8G8B8}, ColorKeyOff, 32'd1);
    send_pixel(32'hFFFF_FFFF);
    // Raw copy turned off through a write whose upper bits are all set.
    set_config(32'(FmtA1R5G5B5), 32'(FmtA1R5G5B5), ColorKeyOff, 32'hFFFF_FFFE);
    send_pixel(32'h7FFF);
    send_pixel(32'hFFFF_8421);
  endtask

  task automatic test_conversions();
    set_config(32'(FmtR5G6B5), 32'(FmtA8R8G8B8), ColorKeyOff, 32'd1);
    send_pixel(32'h0000);
    send_pixel(32'hFFFF);
    send_pixel(32'h1234);
    set_config(32'(FmtA4R4G4B4), 32'(FmtA1R5G5B5), ColorKeyOff, 32'd0);
    send_pixel(32'h7FFF);
    send_pixel(32'h8FFF);
    set_config(32'(FmtA8R8G8B8), 32'(FmtA1R5G5B5), ColorKeyOff, 32'd1);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h8000_0000);
    set_config(32'(FmtA8R8G8B8), 32'(FmtA4R4G4B4), ColorKeyOff, 32'd1);
    send_pixel(32'h1234_5678);
    set_config(32'(FmtX8R8G8B8), 32'(FmtR8G8B8), ColorKeyOff, 32'd1);
    send_pixel(32'hAB12_3456);
    set_config(32'(FmtX1R5G5B5), 32'(FmtR5G6B5), ColorKeyOff, 32'd1);
    send_pixel(32'hFFFF);
    set_config(32'(FmtA8R8G8B8), 32'(FmtX1R5G5B5), ColorKeyOff, 32'd1);
    send_pixel(32'h7F00_0000);
  endtask

  task automatic test_spare_format();
    set_config(32'hFFFF_FFFF, 32'(FmtSpare), ColorKeyOff, 32'd1);
    send_pixel(32'h5A12_3456);
    set_config(32'(FmtSpare), 32'(FmtX8R8G8B8), ColorKeyOff, 32'd1);
    send_pixel(32'h5A12_3456);
    set_config(32'(FmtA4R4G4B4), 32'(FmtSpare), ColorKeyOff, 32'd1);
    send_pixel(32'h9ABC);
  endtask

  task automatic test_color_key();
    set_config(32'(FmtA8R8G8B8), 32'(FmtA8R8G8B8), 32'hFF12_3456, 32'd1);
    send_pixel(32'hFF12_3456);
    send_pixel(32'hFF12_3457);
    // A key with a zero colour part still keys black pixels.
    set_config(32'(FmtR5G6B5), 32'(FmtA1R5G5B5), 32'hFF00_0000, 32'd1);
    send_pixel(32'h0000);
    send_pixel(32'h0001);
    set_config(32'(FmtR8G8B8), 32'(FmtA8R8G8B8), 32'hFFFF_FFFF, 32'd1);
    send_pixel(32'h00FF_FFFF);
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    int unsigned burst;
    logic [2:0]  src;
    logic [2:0]  dst;
    logic [31:0] key;
    logic [31:0] base;
    logic [31:0] px;
    rgba_t       c;
    sent = 0;
    while (sent < 950) begin
      src = 3'($urandom_range(0, 7));
      dst = ($urandom_range(0, 3) == 0) ? src : 3'($urandom_range(0, 7));
      base = $urandom;
      case ($urandom_range(0, 2))
        0: key = ColorKeyOff;
        1: key = $urandom;
        default: begin
          // Aim the key at a pixel that is sent often in this burst.
          c = expand_to_rgba(base, src);
          key = {8'($urandom), c.r, c.g, c.b};
          if (key == ColorKeyOff) key = 32'h0100_0000;
        end
      endcase
      set_config({29'($urandom), src}, {29'($urandom), dst}, key,
                 {31'($urandom), 1'($urandom_range(0, 1))});
      idle_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(10, 50);
      repeat (burst) begin
        case ($urandom_range(0, 7))
          0: px = 32'h0000_0000;
          1: px = 32'hFFFF_FFFF;
          2, 3: px = {8'($urandom), base[23:0]};
          default: px = $urandom;
        endcase
        send_pixel(px);
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_raw_copy();
    test_conversions();
    test_spare_format();
    test_color_key();
    test_random_streams();
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && stray_count == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/pfc_pkg.sv
sv/pfc_expand.sv
sv/pfc_pack.sv
sv/pixel_format_converter.sv
sv/pfc_checker.sv
dv/tb_top.sv
